[hw/rtl/node_table_dedup_liveness_top_assert.svh]
// ----------------------------------------------------------------------------
// node_table_dedup_liveness_top_assert.svh
// Assertion macros used by the node table port checks.
// ----------------------------------------------------------------------------
`ifndef NODE_TABLE_DEDUP_LIVENESS_TOP_ASSERT_SVH
`define NODE_TABLE_DEDUP_LIVENESS_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define NTDL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define NTDL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ntdl_pkg.sv]
// ----------------------------------------------------------------------------
// ntdl_pkg
// Types and codes shared by the node table, its channels and its checker.
// ----------------------------------------------------------------------------
package ntdl_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned NODE_W = 8;
  localparam int unsigned CTR_W  = 32;
  localparam int unsigned TYPE_W = 2;

  localparam logic [TIME_W-1:0] DEFAULT_TIMEOUT_MS = 32'd30000;

  // Item operations
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_HEALTH = 1'b1;

  // Message types
  localparam logic [TYPE_W-1:0] MSG_HEARTBEAT = 2'd0;
  localparam logic [TYPE_W-1:0] MSG_MOTION    = 2'd1;
  localparam logic [TYPE_W-1:0] MSG_RFID      = 2'd2;
  localparam logic [TYPE_W-1:0] MSG_OTHER     = 2'd3;

  // Result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_OFFLINE = 1'b1;

  // One table entry as held in the memory
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [TIME_W-1:0] seen_time;
    logic [TIME_W-1:0] heartbeat_time;
    logic [CTR_W-1:0]  counter;
    logic              online;
    logic              counter_valid;
  } entry_t;

  // One result item
  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] node;
    logic              is_duplicate;
    logic              forward;
    logic              ack_wanted;
    logic              new_node;
    logic              table_full;
    logic              last;
  } result_t;

endpackage

[hw/rtl/ntdl_if.sv]
// ----------------------------------------------------------------------------
// ntdl_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ntdl_item_if import ntdl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [TIME_W-1:0] now_ms;
  logic [NODE_W-1:0] node_id;
  logic [TYPE_W-1:0] msg_type;
  logic [CTR_W-1:0]  msg_counter;

  modport source (output valid, operation, now_ms, node_id, msg_type, msg_counter,
                  input ready);
  modport sink   (input valid, operation, now_ms, node_id, msg_type, msg_counter,
                  output ready);
endinterface

interface ntdl_result_if import ntdl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [NODE_W-1:0] result_node;
  logic              is_duplicate;
  logic              forward;
  logic              ack_wanted;
  logic              new_node;
  logic              table_full;
  logic              last;

  modport source (output valid, result_kind, result_node, is_duplicate, forward,
                  ack_wanted, new_node, table_full, last, input ready);
  modport sink   (input valid, result_kind, result_node, is_duplicate, forward,
                  ack_wanted, new_node, table_full, last, output ready);
endinterface

[hw/rtl/ntdl_mem.sv]
// ----------------------------------------------------------------------------
// ntdl_mem
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ntdl_mem import ntdl_pkg::*; #(
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/ntdl_ctrl.sv]
// ----------------------------------------------------------------------------
// ntdl_ctrl
// Sequencer: walks the entry memory for lookups and health scans, writes
// back updated entries and drives the result register.
// ----------------------------------------------------------------------------
module ntdl_ctrl import ntdl_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 8,
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  ntdl_item_if.sink         item,
  ntdl_result_if.source     result,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data,
  output logic              rd_en,
  output logic [IW-1:0]     rd_addr,
  input  entry_t            rd_data,
  output logic              wr_en,
  output logic [IW-1:0]     wr_addr,
  output entry_t            wr_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PKT   = 2'd1;
  localparam logic [1:0] S_HLT   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]        state, state_next;
  logic [TIME_W-1:0] timeout;
  logic [CW-1:0]     count, count_next;
  logic [IW-1:0]     rd_idx, rd_idx_next;
  logic              rd_pend, rd_pend_next;
  logic              pend_valid, pend_valid_next;
  logic [NODE_W-1:0] pend_node, pend_node_next;
  logic              res_valid;
  result_t           res_q;

  logic [TIME_W-1:0] now_q;
  logic [NODE_W-1:0] node_q;
  logic [TYPE_W-1:0] type_q;
  logic [CTR_W-1:0]  ctr_q;

  logic              accept, out_free, push;
  result_t           push_res;
  logic [CW-1:0]     idx_inc;
  logic              more, hit, dup, ack, timed;
  logic [TIME_W-1:0] ref_time, idle_time;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !res_valid || result.ready;

  // Entry evaluation on the read data
  assign idx_inc   = CW'(rd_idx) + CW'(1);
  assign more      = idx_inc < count;
  assign hit       = rd_pend && (rd_data.node == node_q);
  assign dup       = rd_data.counter_valid && (rd_data.counter == ctr_q);
  assign ack       = (type_q == MSG_MOTION) || (type_q == MSG_RFID);
  assign ref_time  = (rd_data.heartbeat_time != '0) ? rd_data.heartbeat_time
                                                     : rd_data.seen_time;
  assign idle_time = now_q - ref_time;
  assign timed     = rd_data.online && (idle_time > timeout);

  // Sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_idx_next     = rd_idx;
    rd_pend_next    = rd_pend;
    pend_valid_next = pend_valid;
    pend_node_next  = pend_node;
    rd_en           = 1'b0;
    rd_addr         = idx_inc[IW-1:0];
    wr_en           = 1'b0;
    wr_addr         = rd_idx;
    wr_data         = rd_data;
    push            = 1'b0;
    push_res        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rd_idx_next     = '0;
          rd_pend_next    = (count != '0);
          rd_en           = (count != '0);
          rd_addr         = '0;
          pend_valid_next = 1'b0;
          state_next      = (item.operation == OP_HEALTH) ? S_HLT : S_PKT;
        end
      end
      S_PKT: begin
        if (out_free) begin
          push_res.kind       = KIND_VERDICT;
          push_res.node       = node_q;
          push_res.ack_wanted = ack;
          push_res.last       = 1'b1;
          if (hit) begin
            // Known node: refresh and check the counter
            wr_en                  = 1'b1;
            wr_data.seen_time      = now_q;
            wr_data.online         = 1'b1;
            if (type_q == MSG_HEARTBEAT) begin
              wr_data.heartbeat_time = now_q;
            end
            if (!dup) begin
              wr_data.counter       = ctr_q;
              wr_data.counter_valid = 1'b1;
            end
            push                  = 1'b1;
            push_res.is_duplicate = dup;
            push_res.forward      = !dup;
            rd_pend_next          = 1'b0;
            state_next            = S_IDLE;
          end else if (rd_pend && more) begin
            // Advance to the next entry
            rd_en       = 1'b1;
            rd_idx_next = idx_inc[IW-1:0];
          end else begin
            // Unknown node: append or report a full table
            push             = 1'b1;
            push_res.forward = 1'b1;
            rd_pend_next     = 1'b0;
            state_next       = S_IDLE;
            if (count < CW'(MAX_ENTRIES)) begin
              wr_en                  = 1'b1;
              wr_addr                = count[IW-1:0];
              wr_data.node           = node_q;
              wr_data.seen_time      = now_q;
              wr_data.heartbeat_time = (type_q == MSG_HEARTBEAT) ? now_q : '0;
              wr_data.counter        = ctr_q;
              wr_data.counter_valid  = 1'b1;
              wr_data.online         = 1'b1;
              count_next             = count + CW'(1);
              push_res.new_node      = 1'b1;
            end else begin
              push_res.table_full = 1'b1;
            end
          end
        end
      end
      S_HLT: begin
        if (out_free) begin
          if (rd_pend && timed) begin
            // Mark offline; emit the previous report, hold this one
            wr_en           = 1'b1;
            wr_data.online  = 1'b0;
            push            = pend_valid;
            push_res.kind   = KIND_OFFLINE;
            push_res.node   = pend_node;
            pend_valid_next = 1'b1;
            pend_node_next  = rd_data.node;
          end
          if (rd_pend && more) begin
            rd_en       = 1'b1;
            rd_idx_next = idx_inc[IW-1:0];
          end else begin
            rd_pend_next = 1'b0;
            state_next   = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        // Emit the held report as the final one
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          push            = 1'b1;
          push_res.kind   = KIND_OFFLINE;
          push_res.node   = pend_node;
          push_res.last   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rd_idx     <= '0;
      rd_pend    <= 1'b0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
      timeout    <= DEFAULT_TIMEOUT_MS;
    end else begin
      state      <= state_next;
      count      <= count_next;
      rd_idx     <= rd_idx_next;
      rd_pend    <= rd_pend_next;
      pend_valid <= pend_valid_next;
      if (out_free) begin
        res_valid <= push;
      end
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_node <= pend_node_next;
    if (accept) begin
      now_q  <= item.now_ms;
      node_q <= item.node_id;
      type_q <= item.msg_type;
      ctr_q  <= item.msg_counter;
    end
    if (push) begin
      res_q <= push_res;
    end
  end

  assign result.valid        = res_valid;
  assign result.result_kind  = res_q.kind;
  assign result.result_node  = res_q.node;
  assign result.is_duplicate = res_q.is_duplicate;
  assign result.forward      = res_q.forward;
  assign result.ack_wanted   = res_q.ack_wanted;
  assign result.new_node     = res_q.new_node;
  assign result.table_full   = res_q.table_full;
  assign result.last         = res_q.last;

endmodule

[hw/rtl/node_table_dedup_liveness_top.sv]
// ----------------------------------------------------------------------------
// node_table_dedup_liveness_top
// Sender node table with duplicate suppression and liveness timeout.
// ----------------------------------------------------------------------------
// Items enter on the item channel (valid/ready). A packet item looks up its
// sender in the table, appends it if room remains, and gives one verdict
// item on the result channel. A health item scans the table in entry order
// and gives one offline report per online node idle past the timeout; the
// final report carries last. A scan that finds nobody gives no result.
// Entries live in a single-port-read memory; the walk reads one entry per
// cycle while the result register is free. A packet compares entries until
// a hit; a health check reads every filled entry. One item is in work at a
// time; item.ready is high only while the sequencer is idle. A result
// register separates the result channel: a stalled receiver holds the item
// and pauses the scan until it is taken. Reset empties the table (fill
// count zero) and loads the timeout with 30000 ms. cfg_wr_en/cfg_wr_data
// overwrite it; the user must do so while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module node_table_dedup_liveness_top import ntdl_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  logic              clk,
  input  logic              rst,
  ntdl_item_if.sink         item,
  ntdl_result_if.source     result,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;

  // Sequencer
  ntdl_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  // Entry memory
  ntdl_mem #(.DEPTH(MAX_ENTRIES)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

[hw/rtl/ntdl_check.sv]
// ----------------------------------------------------------------------------
// ntdl_check
// Port-level checks on the node table results, bound to the top level.
// ----------------------------------------------------------------------------
`include "node_table_dedup_liveness_top_assert.svh"

module ntdl_check import ntdl_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic              result_kind,
  input logic [NODE_W-1:0] result_node,
  input logic              is_duplicate,
  input logic              forward,
  input logic              ack_wanted,
  input logic              new_node,
  input logic              table_full,
  input logic              last
);

  // Hold a stalled result item
  `NTDL_ASSERT_NXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(result_node) && $stable(result_kind) && $stable(last), "stalled result item changed")

  // A verdict is the only result of its packet and forwards exactly non-duplicates
  `NTDL_ASSERT_IMP(a_verdict, res_valid && (result_kind == KIND_VERDICT), last && (forward != is_duplicate), "bad packet verdict")

  // Offline reports carry no packet flags
  `NTDL_ASSERT_IMP(a_offline, res_valid && (result_kind == KIND_OFFLINE), !is_duplicate && !forward && !ack_wanted && !new_node && !table_full, "offline report with packet flags")

  // A full table neither appends nor drops the packet
  `NTDL_ASSERT_IMP(a_full, res_valid && table_full, !new_node && !is_duplicate && forward, "inconsistent full-table verdict")

endmodule

bind node_table_dedup_liveness_top ntdl_check u_check (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .result_kind  (result.result_kind),
  .result_node  (result.result_node),
  .is_duplicate (result.is_duplicate),
  .forward      (result.forward),
  .ack_wanted   (result.ack_wanted),
  .new_node     (result.new_node),
  .table_full   (result.table_full),
  .last         (result.last)
);

[bench/node_table_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// node_table_checker
// Watches the item and result channels of the node table, keeps its own
// copy of the sender table and the timeout, predicts the verdicts and
// offline reports of each accepted item and compares every accepted result,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module node_table_checker import ntdl_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  logic              clk,
  input  logic              rst,
  ntdl_item_if              item,
  ntdl_result_if            result,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);

  entry_t            entries [MAX_ENTRIES];
  int                fill;
  logic [TIME_W-1:0] timeout_ms;
  result_t           expected_reports [$];

  function automatic void compare_field(string field_name, logic [7:0] want,
                                        logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field_name, want, got);
      mismatches++;
    end
  endfunction

  // Look up or append the sender, then judge its counter
  function automatic void predict_verdict(logic [TIME_W-1:0] now,
                                          logic [NODE_W-1:0] node,
                                          logic [TYPE_W-1:0] mtype,
                                          logic [CTR_W-1:0] ctr);
    int      hit;
    int      i;
    result_t verdict;
    hit = -1;
    for (i = 0; i < fill; i++) begin
      if (hit < 0 && entries[i].node == node) hit = i;
    end
    verdict            = '0;
    verdict.kind       = KIND_VERDICT;
    verdict.node       = node;
    verdict.ack_wanted = (mtype == MSG_MOTION) || (mtype == MSG_RFID);
    verdict.last       = 1'b1;
    if (hit < 0 && fill < MAX_ENTRIES) begin
      hit = fill;
      entries[hit].node           = node;
      entries[hit].heartbeat_time = '0;
      entries[hit].counter        = '0;
      entries[hit].counter_valid  = 1'b0;
      fill++;
      verdict.new_node = 1'b1;
    end
    if (hit < 0) begin
      // table full: no state changes, payload still goes upstream
      verdict.table_full = 1'b1;
      verdict.forward    = 1'b1;
    end else begin
      entries[hit].seen_time = now;
      entries[hit].online    = 1'b1;
      if (mtype == MSG_HEARTBEAT) entries[hit].heartbeat_time = now;
      if (entries[hit].counter_valid && entries[hit].counter == ctr) begin
        verdict.is_duplicate = 1'b1;
      end else begin
        entries[hit].counter       = ctr;
        entries[hit].counter_valid = 1'b1;
      end
      verdict.forward = !verdict.is_duplicate;
    end
    expected_reports.push_back(verdict);
  endfunction

  // Walk the table in entry order and drop every node idle past the timeout
  function automatic void predict_sweep(logic [TIME_W-1:0] now);
    int                i;
    bit                holding;
    result_t           report;
    logic [TIME_W-1:0] base_ms;
    logic [TIME_W-1:0] idle_ms;
    holding = 1'b0;
    report  = '0;
    for (i = 0; i < fill; i++) begin
      // a heartbeat stamped at time zero counts as no heartbeat
      base_ms = (entries[i].heartbeat_time != '0) ? entries[i].heartbeat_time
                                                  : entries[i].seen_time;
      idle_ms = now - base_ms;
      if (entries[i].online && idle_ms > timeout_ms) begin
        entries[i].online = 1'b0;
        if (holding) expected_reports.push_back(report);
        report      = '0;
        report.kind = KIND_OFFLINE;
        report.node = entries[i].node;
        holding     = 1'b1;
      end
    end
    // the final report of the sweep carries last
    if (holding) begin
      report.last = 1'b1;
      expected_reports.push_back(report);
    end
  endfunction

  // Check results, track the register, predict from accepted items
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      fill       = 0;
      timeout_ms = DEFAULT_TIMEOUT_MS;
      expected_reports.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d node %0h",
                   $time, result.result_kind, result.result_node);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("result_kind", 8'(want.kind), 8'(result.result_kind));
          compare_field("result_node", want.node, result.result_node);
          compare_field("is_duplicate", 8'(want.is_duplicate), 8'(result.is_duplicate));
          compare_field("forward", 8'(want.forward), 8'(result.forward));
          compare_field("ack_wanted", 8'(want.ack_wanted), 8'(result.ack_wanted));
          compare_field("new_node", 8'(want.new_node), 8'(result.new_node));
          compare_field("table_full", 8'(want.table_full), 8'(result.table_full));
          compare_field("last", 8'(want.last), 8'(result.last));
        end
      end
      if (cfg_wr_en) timeout_ms = cfg_wr_data;
      if (item.valid && item.ready) begin
        if (item.operation == OP_PACKET) begin
          predict_verdict(item.now_ms, item.node_id, item.msg_type, item.msg_counter);
        end else begin
          predict_sweep(item.now_ms);
        end
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

[bench/node_table_dedup_liveness_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// node_table_dedup_liveness_top_test
// Drives packet and health items into the node table: a directed opening
// that fills the table, hits duplicates, a full table and timeout edges,
// then random phases with different timeouts, sender gaps, receiver stalls
// and one long receiver hold-off. The checker beside the block predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module node_table_dedup_liveness_top_test;
  import ntdl_pkg::*;

  localparam int unsigned MAX_ENTRIES     = 8;
  localparam int unsigned PHASE_ITEMS     = 38;
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [TIME_W-1:0] cfg_wr_data = '0;
  int unsigned       mismatches;
  int unsigned       outstanding;
  int unsigned       cycle_count = 0;

  int unsigned       sender_idle_pct = 0;
  int unsigned       receiver_stall_pct = 0;
  bit                hold_off_req = 1'b0;
  logic [TIME_W-1:0] wall_ms = '0;
  logic [CTR_W-1:0]  last_counter [256] = '{default: '0};
  logic [NODE_W-1:0] roster [MAX_ENTRIES] =
    '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h11, 8'hC8, 8'h21, 8'h80};

  ntdl_item_if   item_bus ();
  ntdl_result_if result_bus ();

  node_table_dedup_liveness_top #(.MAX_ENTRIES(MAX_ENTRIES)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item        (item_bus),
    .result      (result_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  node_table_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .item        (item_bus),
    .result      (result_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned held;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        result_bus.ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
        hold_off_req = 1'b0;
      end
      result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Offer one item and hold it until the block takes it
  task automatic offer_item(input logic op, input logic [TIME_W-1:0] now,
                            input logic [NODE_W-1:0] node,
                            input logic [TYPE_W-1:0] mtype,
                            input logic [CTR_W-1:0] ctr);
    item_bus.valid       <= 1'b1;
    item_bus.operation   <= op;
    item_bus.now_ms      <= now;
    item_bus.node_id     <= node;
    item_bus.msg_type    <= mtype;
    item_bus.msg_counter <= ctr;
    do @(posedge clk); while (!item_bus.ready);
  endtask

  // Drop valid, wait for every expected result, then let a silent sweep end
  task automatic settle();
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIME_W-1:0] ms);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ms;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly well-formed traffic on known nodes, with repeats and some noise
  task automatic random_item(input int unsigned step_max);
    int unsigned       pick;
    logic [NODE_W-1:0] node;
    logic [CTR_W-1:0]  ctr;
    pick    = $urandom_range(99);
    wall_ms = wall_ms + $urandom_range(step_max);
    if (pick < 22) begin
      offer_item(OP_HEALTH, wall_ms, NODE_W'($urandom_range(255)),
                 TYPE_W'($urandom_range(3)), $urandom);
    end else if (pick < 27) begin
      offer_item(OP_PACKET, $urandom, NODE_W'($urandom_range(255)),
                 TYPE_W'($urandom_range(3)), $urandom);
    end else begin
      node = ($urandom_range(9) == 0) ? NODE_W'($urandom_range(255))
                                      : roster[$urandom_range(MAX_ENTRIES - 1)];
      ctr  = ($urandom_range(99) < 35) ? last_counter[node] : $urandom;
      last_counter[node] = ctr;
      offer_item(OP_PACKET, wall_ms, node, TYPE_W'($urandom_range(3)), ctr);
    end
  endtask

  task automatic run_phase(input logic [TIME_W-1:0] timeout, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned step_max,
                           input bit pressure);
    int unsigned n;
    write_timeout(timeout);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    if (pressure) hold_off_req = 1'b1;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      // idle the sender at random between items
      while ($urandom_range(99) < sender_idle_pct) begin
        item_bus.valid <= 1'b0;
        @(posedge clk);
      end
      random_item(step_max);
    end
    settle();
  endtask

  initial begin : stimulus
    int unsigned n;
    item_bus.valid       = 1'b0;
    item_bus.operation   = OP_PACKET;
    item_bus.now_ms      = '0;
    item_bus.node_id     = '0;
    item_bus.msg_type    = MSG_HEARTBEAT;
    item_bus.msg_counter = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first sightings, heartbeat at time zero, repeats at the field extremes
    offer_item(OP_PACKET, 32'h0000_0000, 8'h00, MSG_HEARTBEAT, 32'h0000_0000);
    offer_item(OP_PACKET, 32'd5, 8'h00, MSG_MOTION, 32'h0000_0000);
    offer_item(OP_PACKET, 32'hFFFF_FFFF, 8'hFF, MSG_RFID, 32'hFFFF_FFFF);
    offer_item(OP_PACKET, 32'hFFFF_FFFF, 8'hFF, MSG_OTHER, 32'hFFFF_FFFF);
    // nobody idle, then two nodes out in one sweep, then nobody left online
    offer_item(OP_HEALTH, 32'd10, 8'h00, MSG_HEARTBEAT, '0);
    offer_item(OP_HEALTH, 32'd40000, 8'h00, MSG_HEARTBEAT, '0);
    offer_item(OP_HEALTH, 32'd40001, 8'h00, MSG_HEARTBEAT, '0);
    // fill the remaining entries with every message type
    for (n = 2; n < MAX_ENTRIES; n++) begin
      offer_item(OP_PACKET, 32'd40100 + n, roster[n], TYPE_W'(n % 4), CTR_W'(n));
    end
    // unknown senders against a full table
    offer_item(OP_PACKET, 32'd40200, 8'h4D, MSG_MOTION, 32'h1234_5678);
    offer_item(OP_PACKET, 32'd40201, 8'h33, MSG_HEARTBEAT, 32'h0000_0000);
    // heartbeat brings a node back online, then a repeated counter
    offer_item(OP_PACKET, 32'd50000, 8'h00, MSG_HEARTBEAT, 32'd7);
    offer_item(OP_PACKET, 32'd50010, 8'h00, MSG_OTHER, 32'd7);
    // idle time equal to the timeout holds, one more drops the node
    offer_item(OP_HEALTH, 32'd80000, 8'h00, MSG_HEARTBEAT, '0);
    offer_item(OP_HEALTH, 32'd80001, 8'h00, MSG_HEARTBEAT, '0);
    settle();
    wall_ms = 32'd80001;

    // random phases: smallest timeout, largest timeout, wrap, default, hold-off
    run_phase(32'd1, 0, 0, 3, 1'b0);
    run_phase(32'hFFFF_FFFF, 46, 0, 1 << 20, 1'b0);
    wall_ms = 32'hFFFF_F000;
    run_phase($urandom_range(5000, 100), 0, 46, 2000, 1'b0);
    run_phase(DEFAULT_TIMEOUT_MS, 10, 10, 20000, 1'b0);
    run_phase($urandom_range(500, 50), 0, 0, 300, 1'b1);

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
